// ===== rtl/pslct_pkg.sv =====
// Package for the per-slot level checkpoint tracker: sizes, codes and item types.
`default_nettype none

package pslct_pkg;

  // Table geometry
  localparam int SLOTS      = 64;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int LEVEL_BITS = 24;
  localparam int DELTA_W    = LEVEL_BITS + 1;
  localparam int COUNT_W    = $clog2(SLOTS) + 1;

  // Command codes
  localparam logic CMD_UPDATE     = 1'b0;
  localparam logic CMD_CHECKPOINT = 1'b1;

  // Input item
  typedef struct packed {
    logic                  cmd;
    logic [5:0]            slot;
    logic [LEVEL_BITS-1:0] level;
  } pslct_in_t;

  // Result item
  typedef struct packed {
    logic signed [DELTA_W-1:0] delta;
    logic                      new_entry;
    logic                      all_reached;
    logic [6:0]                over_count;
  } pslct_out_t;

  // One table entry
  typedef struct packed {
    logic [LEVEL_BITS-1:0] level;
    logic [LEVEL_BITS-1:0] checkpoint;
  } pslct_entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic sw_clear;
    logic sw_rd;
    logic sw_wr;
    logic commit;
  } pslct_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic sw_last;
    logic out_free;
  } pslct_sts_t;

endpackage

`default_nettype wire

// ===== rtl/pslct_ctrl.sv =====
// Controller state machine for the per-slot level checkpoint tracker.
`default_nettype none

module pslct_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  input  wire                   in_cmd_i,
  output logic                  in_ready_o,
  input  pslct_pkg::pslct_sts_t sts_i,
  output pslct_pkg::pslct_ctl_t ctl_o
);
  import pslct_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SW_RD = 2'd1;
  localparam logic [1:0] ST_SW_WR = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          if (in_cmd_i == CMD_CHECKPOINT) begin
            ctl_o.sw_clear = 1'b1;
            state_d        = ST_SW_RD;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_SW_RD: begin
        ctl_o.sw_rd = 1'b1;
        state_d     = ST_SW_WR;
      end
      ST_SW_WR: begin
        ctl_o.sw_wr = 1'b1;
        state_d     = sts_i.sw_last ? ST_FIN : ST_SW_RD;
      end
      ST_FIN: begin
        // Hold until the output register can take the result
        if (sts_i.out_free) begin
          ctl_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pslct_dp.sv =====
// Datapath for the per-slot level checkpoint tracker: slot table, counter, result register.
`default_nettype none

module pslct_dp (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  pslct_pkg::pslct_in_t  in_item_i,
  input  pslct_pkg::pslct_ctl_t ctl_i,
  output pslct_pkg::pslct_sts_t sts_o,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output pslct_pkg::pslct_out_t out_item_o
);
  import pslct_pkg::*;

  pslct_entry_t          mem [SLOTS];
  pslct_entry_t          rdata_q;
  logic [SLOTS-1:0]      valid_q;
  logic                  cmd_q;
  logic [SLOT_W-1:0]     slot_q;
  logic [LEVEL_BITS-1:0] lvl_q;
  logic [SLOT_W-1:0]     idx_q;
  logic [COUNT_W-1:0]    cnt_q, cnt_d;
  logic                  out_valid_q;
  pslct_out_t            out_q, res_d;

  logic                  re, we;
  logic [SLOT_W-1:0]     raddr, waddr;
  pslct_entry_t          wdata, upd_entry;
  logic                  at_cp;
  logic                  slot_vld;

  assign sts_o.sw_last  = (idx_q == SLOT_W'(SLOTS - 1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // Latch the item
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q  <= in_item_i.cmd;
      slot_q <= in_item_i.slot[SLOT_W-1:0];
      lvl_q  <= in_item_i.level;
    end
  end

  // Sweep index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (ctl_i.sw_clear) begin
      idx_q <= '0;
    end else if (ctl_i.sw_wr) begin
      idx_q <= idx_q + SLOT_W'(1);
    end
  end

  // Compute the update of one slot
  assign slot_vld = valid_q[slot_q];
  assign at_cp    = (rdata_q.level == rdata_q.checkpoint);

  always_comb begin
    upd_entry.level      = lvl_q;
    upd_entry.checkpoint = rdata_q.checkpoint;
    cnt_d                = cnt_q;
    res_d                = '0;
    if (cmd_q == CMD_CHECKPOINT) begin
      cnt_d = '0;
    end else if (!slot_vld) begin
      upd_entry.checkpoint = lvl_q;
      res_d.new_entry      = 1'b1;
    end else begin
      res_d.delta = DELTA_W'({1'b0, lvl_q}) - DELTA_W'({1'b0, rdata_q.level});
      if (lvl_q > rdata_q.level) begin
        if (at_cp) begin
          cnt_d = cnt_q + COUNT_W'(1);
        end
      end else if (lvl_q < rdata_q.level) begin
        if (lvl_q <= rdata_q.checkpoint) begin
          upd_entry.checkpoint = lvl_q;
          if (!at_cp && cnt_q != '0) begin
            cnt_d = cnt_q - COUNT_W'(1);
            res_d.all_reached = (cnt_q == COUNT_W'(1));
          end
        end
      end
    end
    res_d.over_count = 7'(cnt_d);
  end

  // Table port selection
  always_comb begin
    re    = ctl_i.load || ctl_i.sw_rd;
    raddr = ctl_i.load ? in_item_i.slot[SLOT_W-1:0] : idx_q;
    we    = ctl_i.sw_wr || (ctl_i.commit && cmd_q == CMD_UPDATE);
    if (ctl_i.sw_wr) begin
      waddr            = idx_q;
      wdata.level      = rdata_q.level;
      wdata.checkpoint = rdata_q.level;
    end else begin
      waddr = slot_q;
      wdata = upd_entry;
    end
  end

  // Slot table memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  // Valid bits and counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      cnt_q   <= '0;
    end else if (ctl_i.commit) begin
      cnt_q <= cnt_d;
      if (cmd_q == CMD_UPDATE) begin
        valid_q[slot_q] <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.commit) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/per_slot_level_checkpoint_tracker_top.sv =====
// Top level of the per-slot level checkpoint tracker.
//
// Input channel (in_valid_i/in_ready_o/in_item_i) takes one item: a level
// update for one slot or a checkpoint command. Output channel
// (out_valid_o/out_ready_i/out_item_o) returns exactly one result per item.
// Items are processed one at a time. An update reads its slot entry from the
// table memory at the accept edge and writes it back when it commits, once
// the output register is free. No new item is taken until the last one has
// committed its result. A checkpoint command walks the whole table with one
// read step and one write step per slot, then commits its result.
// Reset clears the slot valid bits, the over-checkpoint counter and the
// output valid flag; table contents are left as they are and are only used
// for slots already written. The result sits in an output register: while
// the receiver stalls, the block still accepts the next item and works on it,
// then holds in its final step until the register is free.
`default_nettype none

module per_slot_level_checkpoint_tracker_top (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  pslct_pkg::pslct_in_t  in_item_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output pslct_pkg::pslct_out_t out_item_o
);
  import pslct_pkg::*;

  pslct_ctl_t ctl;
  pslct_sts_t sts;

  pslct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_item_i.cmd),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  pslct_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
